>>> rtl/rrd_pkg.sv
// Shared types, constants and the saturation helper for the reflect/refract core.
package rrd_pkg;

  localparam int CompWidth = 16;
  localparam int FracBits  = 14;

  typedef struct packed {
    logic signed [CompWidth-1:0] dir_x;
    logic signed [CompWidth-1:0] dir_y;
    logic signed [CompWidth-1:0] dir_z;
    logic signed [CompWidth-1:0] norm_x;
    logic signed [CompWidth-1:0] norm_y;
    logic signed [CompWidth-1:0] norm_z;
    logic        [CompWidth-1:0] eta;
  } item_t;

  typedef struct packed {
    logic signed [CompWidth-1:0] refl_x;
    logic signed [CompWidth-1:0] refl_y;
    logic signed [CompWidth-1:0] refl_z;
    logic signed [CompWidth-1:0] refr_x;
    logic signed [CompWidth-1:0] refr_y;
    logic signed [CompWidth-1:0] refr_z;
    logic                        total_internal;
  } res_t;

  // Clamp a wide signed value to the component range.
  function automatic logic signed [CompWidth-1:0] sat_w(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = (64'sd1 <<< (CompWidth - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (v > hi) begin
      return hi[CompWidth-1:0];
    end else if (v < lo) begin
      return lo[CompWidth-1:0];
    end
    return v[CompWidth-1:0];
  endfunction

endpackage

>>> rtl/rrd_sqrt.sv
// Pipelined integer square root, one root bit per stage, with a side-band carried along.
module rrd_sqrt #(
  parameter int IN_W   = 40,
  parameter int SIDE_W = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [IN_W-1:0]     x,
  input  logic [SIDE_W-1:0]   side_in,
  output logic                out_valid,
  output logic [IN_W/2-1:0]   root,
  output logic [SIDE_W-1:0]   side_out
);

  localparam int RB = IN_W / 2;

  logic              vld  [0:RB];
  logic [IN_W-1:0]   xs   [0:RB];
  logic [RB-1:0]     rem  [0:RB];
  logic [RB-1:0]     rt   [0:RB];
  logic [SIDE_W-1:0] side [0:RB];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
    if (en) begin
      xs[0]   <= x;
      rem[0]  <= '0;
      rt[0]   <= '0;
      side[0] <= side_in;
    end
  end

  for (genvar g = 0; g < RB; g++) begin : g_stage
    logic [RB+1:0] r2;
    logic [RB+1:0] trial;
    logic [RB+1:0] diff;
    logic          take;

    always_comb begin
      r2    = {rem[g], xs[g][IN_W-1 -: 2]};
      trial = {rt[g], 2'b01};
      diff  = r2 - trial;
      take  = (r2 >= trial);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g+1] <= 1'b0;
      end else if (en) begin
        vld[g+1] <= vld[g];
      end
      if (en) begin
        xs[g+1]   <= xs[g] << 2;
        rem[g+1]  <= take ? diff[RB-1:0] : r2[RB-1:0];
        rt[g+1]   <= {rt[g][RB-2:0], take};
        side[g+1] <= side[g];
      end
    end
  end

  assign out_valid = vld[RB];
  assign root      = rt[RB];
  assign side_out  = side[RB];

endmodule

>>> rtl/reflect_refract_direction_core.sv
// Top level: mirror and Snell refraction of a fixed-point direction, fully pipelined.
// The square root unit yields R root bits (R = 20 at defaults).
// Throughput: one item per cycle unless the output stalls; the whole pipeline advances together on one enable.
// The enable drops only while a finished item sits at the output and is stalled.
// Reset clears every stage valid bit; data registers are not reset.
// The square root pipeline (an input register plus one root bit per stage) sets the depth.
module reflect_refract_direction_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_stall,
  input  rrd_pkg::item_t item,
  output logic           res_valid,
  input  logic           res_stall,
  output rrd_pkg::res_t  res
);

  localparam int W      = rrd_pkg::CompWidth;
  localparam int F      = rrd_pkg::FracBits;
  localparam int SUM_W  = 2 * W + 2;          // exact dot product
  localparam int ESQ_W  = 2 * W - F + 1;      // eta^2 rounded
  localparam int C1Q_W  = 2 * W - F;          // c1^2 rounded
  localparam int T_W    = 2 * W - F + 2;      // 1 - c1^2
  localparam int P5_W   = ESQ_W + 1 + T_W;    // eta^2 * t
  localparam int C2_W   = P5_W - F + 1;
  localparam int SQ_RAW = C2_W - 1 + F;
  localparam int SQ_W   = SQ_RAW + (SQ_RAW % 2);
  localparam int RB     = SQ_W / 2;
  localparam int EC1_W  = 2 * W - F + 1;
  localparam int K_W    = ((EC1_W > RB) ? EC1_W : RB) + 2;
  localparam int RS_W   = (((2 * W + 1) > (K_W + W)) ? (2 * W + 1) : (K_W + W)) + 1;
  localparam int MR_W   = 2 * W - F + 3;
  localparam int SIDE_W = 7 * W + EC1_W + 2 + 3 * W;

  logic en;
  assign en         = !(res_valid && res_stall);
  assign item_stall = !en;

  // ---------------- stage 1: products d.n and eta^2
  logic                 v1;
  logic signed [W-1:0]  d1 [3];
  logic signed [W-1:0]  n1 [3];
  logic        [W-1:0]  eta1;
  logic signed [2*W-1:0] pdn1 [3];
  logic        [2*W-1:0] pee1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= item_valid;
    end
    if (en) begin
      d1[0]   <= item.dir_x;
      d1[1]   <= item.dir_y;
      d1[2]   <= item.dir_z;
      n1[0]   <= item.norm_x;
      n1[1]   <= item.norm_y;
      n1[2]   <= item.norm_z;
      eta1    <= item.eta;
      pdn1[0] <= item.dir_x * item.norm_x;
      pdn1[1] <= item.dir_y * item.norm_y;
      pdn1[2] <= item.dir_z * item.norm_z;
      pee1    <= item.eta * item.eta;
    end
  end

  // ---------------- stage 2: round and saturate the dot product, round eta^2
  logic signed [SUM_W-1:0] dsum;
  logic        [2*W:0]     pee_r;
  always_comb begin
    dsum  = SUM_W'(pdn1[0]) + SUM_W'(pdn1[1]) + SUM_W'(pdn1[2])
          + (SUM_W'(1) << (F - 1));
    pee_r = {1'b0, pee1} + ((2 * W + 1)'(1) << (F - 1));
  end

  logic                 v2;
  logic signed [W-1:0]  d2 [3];
  logic signed [W-1:0]  n2 [3];
  logic        [W-1:0]  eta2;
  logic signed [W-1:0]  dot2;
  logic [ESQ_W-1:0]     esq2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      d2   <= d1;
      n2   <= n1;
      eta2 <= eta1;
      dot2 <= rrd_pkg::sat_w(64'(dsum >>> F));
      esq2 <= ESQ_W'(pee_r >> F);
    end
  end

  // ---------------- stage 3: c1 = |dot|, c1^2 and the mirror products
  logic [W-1:0] c1_mag;
  always_comb begin
    c1_mag = dot2[W-1] ? W'(-{dot2[W-1], dot2}) : W'(dot2);
  end

  logic                  v3;
  logic signed [W-1:0]   d3 [3];
  logic signed [W-1:0]   n3 [3];
  logic        [W-1:0]   eta3;
  logic                  neg3;
  logic [W-1:0]          c13;
  logic [2*W-1:0]        c1c13;
  logic [ESQ_W-1:0]      esq3;
  logic signed [2*W-1:0] pm3 [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
    if (en) begin
      d3    <= d2;
      n3    <= n2;
      eta3  <= eta2;
      neg3  <= dot2[W-1];
      c13   <= c1_mag;
      c1c13 <= c1_mag * c1_mag;
      esq3  <= esq2;
      for (int i = 0; i < 3; i++) begin
        pm3[i] <= dot2 * n2[i];
      end
    end
  end

  // ---------------- stage 4: 1 - c1^2, mirror result, eta*c1
  logic [2*W:0]           c1q_r;
  logic signed [T_W-1:0]  t_c;
  logic signed [W-1:0]    refl_c [3];
  always_comb begin
    c1q_r = {1'b0, c1c13} + ((2 * W + 1)'(1) << (F - 1));
    t_c   = (T_W'(1) << F) - T_W'(C1Q_W'(c1q_r >> F));
    for (int i = 0; i < 3; i++) begin
      refl_c[i] = rrd_pkg::sat_w(64'(MR_W'(d3[i])
                  - MR_W'((pm3[i] + ((2 * W)'(1) << (F - 2))) >>> (F - 1))));
    end
  end

  logic                 v4;
  logic signed [W-1:0]  d4 [3];
  logic signed [W-1:0]  n4 [3];
  logic        [W-1:0]  eta4;
  logic                 neg4;
  logic [ESQ_W-1:0]     esq4;
  logic signed [T_W-1:0] t4;
  logic signed [W-1:0]  refl4 [3];
  logic [2*W-1:0]       pec4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
    if (en) begin
      d4    <= d3;
      n4    <= n3;
      eta4  <= eta3;
      neg4  <= neg3;
      esq4  <= esq3;
      t4    <= t_c;
      refl4 <= refl_c;
      pec4  <= eta3 * c13;
    end
  end

  // ---------------- stage 5: eta^2 * t, round eta*c1
  logic [2*W:0] pec_r;
  always_comb begin
    pec_r = {1'b0, pec4} + ((2 * W + 1)'(1) << (F - 1));
  end

  logic                   v5;
  logic signed [W-1:0]    d5 [3];
  logic signed [W-1:0]    n5 [3];
  logic        [W-1:0]    eta5;
  logic                   neg5;
  logic signed [W-1:0]    refl5 [3];
  logic [EC1_W-1:0]       ec15;
  logic signed [P5_W-1:0] pt5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v4;
    end
    if (en) begin
      d5    <= d4;
      n5    <= n4;
      eta5  <= eta4;
      neg5  <= neg4;
      refl5 <= refl4;
      ec15  <= EC1_W'(pec_r >> F);
      pt5   <= P5_W'($signed({1'b0, esq4}) * t4);
    end
  end

  // ---------------- c2 = 1 - round(eta^2 t); feed the root pipeline
  logic signed [C2_W-1:0] c2;
  logic                   tir5;
  logic [SQ_W-1:0]        sq_x;
  logic [SIDE_W-1:0]      side_in;
  always_comb begin
    c2      = (C2_W'(1) << F)
            - C2_W'((pt5 + (P5_W'(1) << (F - 1))) >>> F);
    tir5    = c2[C2_W-1];
    sq_x    = tir5 ? '0 : SQ_W'({c2[C2_W-2:0], {F{1'b0}}});
    side_in = {d5[0], d5[1], d5[2], n5[0], n5[1], n5[2], eta5, ec15, neg5, tir5,
               refl5[0], refl5[1], refl5[2]};
  end

  logic              vs;
  logic [RB-1:0]     sq;
  logic [SIDE_W-1:0] side_out;

  rrd_sqrt #(
    .IN_W   (SQ_W),
    .SIDE_W (SIDE_W)
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v5),
    .x         (sq_x),
    .side_in   (side_in),
    .out_valid (vs),
    .root      (sq),
    .side_out  (side_out)
  );

  logic signed [W-1:0] ds [3];
  logic signed [W-1:0] ns [3];
  logic        [W-1:0] etas;
  logic [EC1_W-1:0]    ec1s;
  logic                negs;
  logic                tirs;
  logic signed [W-1:0] refls [3];
  assign {ds[0], ds[1], ds[2], ns[0], ns[1], ns[2], etas, ec1s, negs, tirs,
          refls[0], refls[1], refls[2]} = side_out;

  // ---------------- stage 7: refraction coefficient and the final products
  logic signed [K_W-1:0] coef;
  logic signed [K_W-1:0] kc;
  always_comb begin
    coef = K_W'(ec1s) - K_W'(sq);
    kc   = negs ? coef : -coef;
  end

  logic                      v7;
  logic                      tir7;
  logic signed [W-1:0]       refl7 [3];
  logic signed [2*W:0]       pe7 [3];
  logic signed [K_W+W-1:0]   pk7 [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (en) begin
      v7 <= vs;
    end
    if (en) begin
      tir7  <= tirs;
      refl7 <= refls;
      for (int i = 0; i < 3; i++) begin
        pe7[i] <= $signed({1'b0, etas}) * ds[i];
        pk7[i] <= kc * ns[i];
      end
    end
  end

  // ---------------- stage 8: sum, round, saturate; zero on total internal reflection
  logic signed [RS_W-1:0] rs [3];
  logic signed [W-1:0]    refr_c [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rs[i]     = RS_W'(pe7[i]) + RS_W'(pk7[i]) + (RS_W'(1) << (F - 1));
      refr_c[i] = tir7 ? '0 : rrd_pkg::sat_w(64'(rs[i] >>> F));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en) begin
      res_valid <= v7;
    end
    if (en) begin
      res.refl_x         <= refl7[0];
      res.refl_y         <= refl7[1];
      res.refl_z         <= refl7[2];
      res.refr_x         <= refr_c[0];
      res.refr_y         <= refr_c[1];
      res.refr_z         <= refr_c[2];
      res.total_internal <= tir7;
    end
  end

  // ---------------- checks
  a_tir_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.total_internal |->
      res.refr_x == '0 && res.refr_y == '0 && res.refr_z == '0)
    else $error("refracted vector not zero on total internal reflection");

  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> !item_stall)
    else $error("input stalled while output holds no item");

  a_reset_clears: assert property (@(posedge clk)
    $past(rst) |-> !res_valid)
    else $error("output valid right after reset");

endmodule

>>> dv/tb.sv
// Self-checking testbench for the reflect/refract direction core.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Frac = rrd_pkg::FracBits;
  localparam longint One = 64'sd1 <<< Frac;
  localparam int IdleLimit = 5000;
  localparam int DrainCycles = 60;
  localparam int RandomItems = 1030;

  // Holds expected rays in order and compares the core's results against them.
  class ray_scoreboard;
    rrd_pkg::res_t pending[$];
    int   errors;
    int   accepted;
    int   checked;
    int   tir_seen;

    function automatic logic signed [15:0] clamp16(longint v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return 16'sh8000;
      return v[15:0];
    endfunction

    // floor(v / 2^s + 1/2); arithmetic shift floors negative values
    function automatic longint rnd_shr(longint v, int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint unsigned root_floor(longint unsigned x);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x = x - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function automatic rrd_pkg::res_t trace_ray(rrd_pkg::item_t it);
      rrd_pkg::res_t o;
      longint d[3];
      longint n[3];
      longint eta, dot, c1, c1sq, eta_sq, c2, sq, ec1, k;
      d[0] = it.dir_x;  d[1] = it.dir_y;  d[2] = it.dir_z;
      n[0] = it.norm_x; n[1] = it.norm_y; n[2] = it.norm_z;
      eta = longint'({48'd0, it.eta});
      dot = clamp16(rnd_shr(d[0] * n[0] + d[1] * n[1] + d[2] * n[2], Frac));
      o.refl_x = clamp16(d[0] - rnd_shr(dot * n[0], Frac - 1));
      o.refl_y = clamp16(d[1] - rnd_shr(dot * n[1], Frac - 1));
      o.refl_z = clamp16(d[2] - rnd_shr(dot * n[2], Frac - 1));
      c1 = dot < 0 ? -dot : dot;
      c1sq = rnd_shr(c1 * c1, Frac);
      eta_sq = rnd_shr(eta * eta, Frac);
      c2 = One - rnd_shr(eta_sq * (One - c1sq), Frac);
      if (c2 < 0) begin
        o.refr_x = '0;
        o.refr_y = '0;
        o.refr_z = '0;
        o.total_internal = 1'b1;
        return o;
      end
      if (c2 > (64'sh7fffffffffffffff >>> Frac)) c2 = 64'sh7fffffffffffffff >>> Frac;
      sq = longint'(root_floor(longint'(c2) << Frac));
      ec1 = rnd_shr(eta * c1, Frac);
      k = dot < 0 ? ec1 - sq : sq - ec1;
      o.refr_x = clamp16(rnd_shr(eta * d[0] + k * n[0], Frac));
      o.refr_y = clamp16(rnd_shr(eta * d[1] + k * n[1], Frac));
      o.refr_z = clamp16(rnd_shr(eta * d[2] + k * n[2], Frac));
      o.total_internal = 1'b0;
      return o;
    endfunction

    task automatic report(string what, longint got, longint want);
      errors++;
      $display("MISMATCH %s: got %0d, expected %0d (result %0d)", what, got, want, checked);
    endtask

    function automatic void note_item(rrd_pkg::item_t it);
      accepted++;
      pending.push_back(trace_ray(it));
    endfunction

    task automatic check_result(rrd_pkg::res_t r);
      rrd_pkg::res_t e;
      if (pending.size() == 0) begin
        report("unexpected result", 0, 0);
        return;
      end
      e = pending.pop_front();
      if (e.total_internal) tir_seen++;
      if (r.refl_x != e.refl_x) report("refl_x", r.refl_x, e.refl_x);
      if (r.refl_y != e.refl_y) report("refl_y", r.refl_y, e.refl_y);
      if (r.refl_z != e.refl_z) report("refl_z", r.refl_z, e.refl_z);
      if (r.refr_x != e.refr_x) report("refr_x", r.refr_x, e.refr_x);
      if (r.refr_y != e.refr_y) report("refr_y", r.refr_y, e.refr_y);
      if (r.refr_z != e.refr_z) report("refr_z", r.refr_z, e.refr_z);
      if (r.total_internal != e.total_internal)
        report("total_internal", r.total_internal, e.total_internal);
      checked++;
    endtask
  endclass

  logic           clk;
  logic           rst;
  logic           item_valid;
  logic           item_stall;
  rrd_pkg::item_t item;
  logic           res_valid;
  logic           res_stall = 1'b0;
  rrd_pkg::res_t  res;

  ray_scoreboard sb;
  int idle_cycles = 0;
  int stall_mode = 0;
  int stall_left = 0;

  reflect_refract_direction_core DUT (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item      (item),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Observe both handshakes at the edge; the watchdog ends a hung run.
  always @(posedge clk) begin
    if (!rst) begin
      if (item_valid && !item_stall) sb.note_item(item);
      if (res_valid && !res_stall) sb.check_result(res);
      if ((item_valid && !item_stall) || (res_valid && !res_stall)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("watchdog: no progress for %0d cycles", IdleLimit);
        $display("tb failed");
        $finish;
      end
    end
  end

  // Receiver stall pattern: phases of no stall, light random stall and heavy random stall.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(10, 80);
      res_stall  <= 1'b0;
    end else begin
      stall_left <= stall_left - 1;
      case (stall_mode)
        0: res_stall <= 1'b0;
        1: res_stall <= ($urandom_range(0, 99) < 35);
        default: res_stall <= ($urandom_range(0, 99) < 85);
      endcase
    end
  end

  // Present one item and hold it until the core takes it.
  task automatic send_item(rrd_pkg::item_t it);
    item       <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
  endtask

  task automatic pause(int cycles);
    item_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  function automatic rrd_pkg::item_t make_item(int dx, int dy, int dz, int nx, int ny,
                                               int nz, int e);
    rrd_pkg::item_t it;
    it.dir_x = dx[15:0]; it.dir_y = dy[15:0]; it.dir_z = dz[15:0];
    it.norm_x = nx[15:0]; it.norm_y = ny[15:0]; it.norm_z = nz[15:0];
    it.eta = e[15:0];
    return it;
  endfunction

  // Mostly rays and normals with components within unit range and plausible eta; some raw noise.
  function automatic rrd_pkg::item_t random_ray();
    rrd_pkg::item_t it;
    int             pick;
    it = rrd_pkg::item_t'(112'({$urandom, $urandom, $urandom, $urandom}));
    pick = $urandom_range(0, 9);
    if (pick < 7) begin
      it.dir_x  = 16'($urandom_range(0, 32768) - 16384);
      it.dir_y  = 16'($urandom_range(0, 32768) - 16384);
      it.dir_z  = 16'($urandom_range(0, 32768) - 16384);
      it.norm_x = 16'($urandom_range(0, 23170) - 11585);
      it.norm_y = 16'($urandom_range(0, 23170) - 11585);
      it.norm_z = 16'($urandom_range(0, 23170) - 11585);
      it.eta    = 16'($urandom_range(8192, 32768));
    end else if (pick < 8) begin
      it.eta = 16'($urandom_range(0, 65535));
    end
    return it;
  endfunction

  initial begin
    rrd_pkg::item_t directed[$];
    sb = new();
    rst        = 1'b1;
    item_valid = 1'b0;
    item       = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Head-on, grazing, flipped normal, zero eta, total internal reflection, extremes.
    directed.push_back(make_item(0, 0, -16384, 0, 0, 16384, 16384));
    directed.push_back(make_item(0, 0, 16384, 0, 0, 16384, 16384));
    directed.push_back(make_item(11585, 0, -11585, 0, 0, 16384, 10923));
    directed.push_back(make_item(11585, 0, 11585, 0, 0, 16384, 24576));
    directed.push_back(make_item(16384, 0, -1000, 0, 0, 16384, 24576));
    directed.push_back(make_item(16384, 0, -100, 0, 0, 16384, 65535));
    directed.push_back(make_item(9459, 9459, -9459, 0, 0, 16384, 0));
    directed.push_back(make_item(16384, 0, 0, 0, 0, 16384, 16384));
    directed.push_back(make_item(-32768, -32768, -32768, -32768, -32768, -32768, 65535));
    directed.push_back(make_item(32767, 32767, 32767, -32768, -32768, -32768, 65535));
    directed.push_back(make_item(32767, 32767, 32767, 32767, 32767, 32767, 0));
    directed.push_back(make_item(-32768, 32767, -32768, 32767, -32768, 32767, 1));
    directed.push_back(make_item(0, 0, 0, 0, 0, 0, 0));
    directed.push_back(make_item(0, 0, 0, 0, 0, 0, 65535));
    directed.push_back(make_item(-1, -1, -1, -1, -1, -1, 32768));
    directed.push_back(make_item(1, 1, 1, 1, 1, 1, 16383));
    directed.push_back(make_item(5000, -7000, -12000, 0, 16384, 0, 20000));
    directed.push_back(make_item(-5000, 12000, 7000, 16384, 0, 0, 12000));
    directed.push_back(make_item(0, -16384, 0, 0, -32768, 0, 16384));
    directed.push_back(make_item(-16384, 0, 0, 32767, 0, 0, 40000));
    foreach (directed[i]) send_item(directed[i]);

    for (int i = 0; i < RandomItems; i++) begin
      if ($urandom_range(0, 99) < 12) pause($urandom_range(1, 20));
      // Drain the whole pipeline once, partway through the run.
      if (i == RandomItems / 2) begin
        item_valid <= 1'b0;
        do @(posedge clk); while (sb.pending.size() != 0);
      end
      send_item(random_ray());
    end
    item_valid <= 1'b0;

    do @(posedge clk); while (sb.pending.size() != 0);
    repeat (DrainCycles) @(posedge clk);

    $display("covered %0d rays, %0d results checked, %0d with total internal reflection",
             sb.accepted, sb.checked, sb.tir_seen);
    $display("mismatches: %0d", sb.errors);
    if (sb.errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end
endmodule
